FILE: hw/rtl/motor_pwm_duty_stepper_unit_macros.svh
// Assertion helpers shared by the motor PWM duty stepper RTL.
// Each macro samples on i_clk and is off while i_rst_n is low.
`ifndef MOTOR_PWM_DUTY_STEPPER_UNIT_MACROS_SVH
`define MOTOR_PWM_DUTY_STEPPER_UNIT_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define MPDS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define MPDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/mpds_pkg.sv
package mpds_pkg;

    localparam int unsigned COUNTER_BITS_DEF = 16;

    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned DUTY_W   = 7;
    localparam int unsigned PROD_W   = PERIOD_W + DUTY_W;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd50000;
    localparam logic [DUTY_W-1:0]   DUTY_RESET   = 7'd50;
    localparam logic [DUTY_W-1:0]   DUTY_STEP    = 7'd5;
    localparam logic [DUTY_W-1:0]   DUTY_MAX     = 7'd100;
    localparam logic [DUTY_W-1:0]   DUTY_MIN     = 7'd5;

    // period * duty after reset, and the low phase length that goes with it
    localparam logic [PROD_W-1:0] PROD_RESET = PROD_W'(50000 * 50);
    localparam longint unsigned   LEN_RESET  = 50000 - (50000 * 50) / 100;

    // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for every x below 2^23
    localparam int unsigned         RECIP_W     = 24;
    localparam logic [RECIP_W-1:0]  RECIP_100   = 24'd10737419;
    localparam int unsigned         RECIP_SHIFT = 30;

    localparam logic [3:0] KEY_INC = 4'b1101;
    localparam logic [3:0] KEY_DEC = 4'b1011;

    localparam logic [1:0] HOLD_NONE = 2'd0;
    localparam logic [1:0] HOLD_INC  = 2'd1;
    localparam logic [1:0] HOLD_DEC  = 2'd2;

    typedef struct packed {
        logic       step;
        logic       motor_enable;
        logic [3:0] buttons_n;
    } t_tick_ctrl;

endpackage

FILE: hw/rtl/mpds_in_if.sv
interface mpds_in_if;
    logic       valid;
    logic       ready;
    logic       motor_enable;
    logic       reverse_dir;
    logic [3:0] buttons_n;

    modport source (output valid, output motor_enable, output reverse_dir,
                    output buttons_n, input ready);
    modport sink   (input valid, input motor_enable, input reverse_dir,
                    input buttons_n, output ready);
endinterface

FILE: hw/rtl/mpds_out_if.sv
interface mpds_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] drive_pins;
    logic [6:0] duty_percent;

    modport source (output valid, output drive_pins, output duty_percent, input ready);
    modport sink   (input valid, input drive_pins, input duty_percent, output ready);
endinterface

FILE: hw/rtl/mpds_duty_keys.sv
module mpds_duty_keys (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mpds_pkg::t_tick_ctrl         i_ctrl,
    output logic [mpds_pkg::DUTY_W-1:0]  o_duty,
    output logic [mpds_pkg::DUTY_W-1:0]  o_duty_next
);

    logic [mpds_pkg::DUTY_W-1:0] r_duty, n_duty;
    logic [1:0]                  r_hold, n_hold;

    // Step duty on key release; a press only starts from the no-key state.
    always_comb begin
        n_duty = r_duty;
        n_hold = r_hold;
        if (i_ctrl.step) begin
            case (r_hold)
                mpds_pkg::HOLD_INC: begin
                    if (i_ctrl.buttons_n != mpds_pkg::KEY_INC) begin
                        if (r_duty < mpds_pkg::DUTY_MAX) begin
                            n_duty = r_duty + mpds_pkg::DUTY_STEP;
                        end
                        n_hold = mpds_pkg::HOLD_NONE;
                    end
                end
                mpds_pkg::HOLD_DEC: begin
                    if (i_ctrl.buttons_n != mpds_pkg::KEY_DEC) begin
                        if (r_duty > mpds_pkg::DUTY_MIN) begin
                            n_duty = r_duty - mpds_pkg::DUTY_STEP;
                        end
                        n_hold = mpds_pkg::HOLD_NONE;
                    end
                end
                default: begin
                    if (i_ctrl.motor_enable && i_ctrl.buttons_n == mpds_pkg::KEY_INC) begin
                        n_hold = mpds_pkg::HOLD_INC;
                    end else if (i_ctrl.motor_enable &&
                                 i_ctrl.buttons_n == mpds_pkg::KEY_DEC) begin
                        n_hold = mpds_pkg::HOLD_DEC;
                    end else begin
                        n_hold = mpds_pkg::HOLD_NONE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty <= mpds_pkg::DUTY_RESET;
            r_hold <= mpds_pkg::HOLD_NONE;
        end else begin
            r_duty <= n_duty;
            r_hold <= n_hold;
        end
    end

    assign o_duty      = r_duty;
    assign o_duty_next = n_duty;

endmodule

FILE: hw/rtl/mpds_phase_len.sv
module mpds_phase_len #(
    parameter int unsigned COUNTER_BITS = mpds_pkg::COUNTER_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [mpds_pkg::PERIOD_W-1:0]  i_period,
    input  logic [mpds_pkg::PERIOD_W-1:0]  i_period_next,
    input  logic [mpds_pkg::DUTY_W-1:0]    i_duty_next,
    output logic [COUNTER_BITS-1:0]        o_on_len,
    output logic [COUNTER_BITS-1:0]        o_off_len
);

    localparam longint unsigned CNT_MAX = (64'd1 << COUNTER_BITS) - 64'd1;
    localparam int unsigned     QUOT_W  = mpds_pkg::PROD_W + mpds_pkg::RECIP_W;

    logic [mpds_pkg::PROD_W-1:0]   r_prod;
    logic [QUOT_W-1:0]             w_scaled;
    logic [mpds_pkg::PERIOD_W-1:0] w_on;
    logic [mpds_pkg::PERIOD_W-1:0] w_off;

    // Keep period * duty for the state the block will hold next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod <= mpds_pkg::PROD_RESET;
        end else begin
            r_prod <= mpds_pkg::PROD_W'(i_period_next) * mpds_pkg::PROD_W'(i_duty_next);
        end
    end

    // Divide by 100 through the reciprocal.
    assign w_scaled = QUOT_W'(r_prod) * QUOT_W'(mpds_pkg::RECIP_100);
    assign w_on     = w_scaled[mpds_pkg::RECIP_SHIFT +: mpds_pkg::PERIOD_W];
    assign w_off    = (w_on > i_period) ? '0 : i_period - w_on;

    // Saturate to the counter range.
    assign o_on_len  = (64'(w_on) > CNT_MAX) ? COUNTER_BITS'(CNT_MAX) : COUNTER_BITS'(w_on);
    assign o_off_len = (64'(w_off) > CNT_MAX) ? COUNTER_BITS'(CNT_MAX) : COUNTER_BITS'(w_off);

endmodule

FILE: hw/rtl/motor_pwm_duty_stepper_unit.sv
// An input item waits in the input register, its result in the output one;
// a result held while o_out.ready is low stalls input. Throughput: one tick
// item per cycle unless stalled; counter, level, duty loops add no register.
// Reset: i_rst_n synchronous, active low; duty 50, period 50000, level low,
// counter 0, phase length 25000 (saturated to the counter), no key held.
`include "motor_pwm_duty_stepper_unit_macros.svh"

module motor_pwm_duty_stepper_unit #(
    parameter int unsigned COUNTER_BITS = mpds_pkg::COUNTER_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    mpds_in_if.sink                        i_in,
    mpds_out_if.source                     o_out,
    input  logic                           i_cfg_we,
    input  logic [mpds_pkg::PERIOD_W-1:0]  i_cfg_wdata
);

    localparam longint unsigned CNT_MAX = (64'd1 << COUNTER_BITS) - 64'd1;
    localparam longint unsigned LEN_RST =
        (mpds_pkg::LEN_RESET > CNT_MAX) ? CNT_MAX : mpds_pkg::LEN_RESET;

    // ---------------------------------------------------------------
    // Input register: holds one tick item until the step stage takes it.
    // ---------------------------------------------------------------
    logic       r_in_valid;
    logic       r_en;
    logic       r_rev;
    logic [3:0] r_btn;

    // Output register
    logic                          r_out_valid;
    logic [1:0]                    r_out_pins;
    logic [mpds_pkg::DUTY_W-1:0]   r_out_duty;

    // PWM time base
    logic                          r_level;
    logic [COUNTER_BITS-1:0]       r_elapsed;
    logic [COUNTER_BITS-1:0]       r_len;
    logic [mpds_pkg::PERIOD_W-1:0] r_period, n_period;

    logic                          w_step;
    logic                          w_toggle;
    logic [1:0]                    w_pins;
    logic [COUNTER_BITS-1:0]       w_on_len;
    logic [COUNTER_BITS-1:0]       w_off_len;
    logic [mpds_pkg::DUTY_W-1:0]   w_duty;
    logic [mpds_pkg::DUTY_W-1:0]   w_duty_next;
    mpds_pkg::t_tick_ctrl          w_ctrl;

    // Advance the held item when the output register is free or draining.
    assign w_step     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_en  <= i_in.motor_enable;
            r_rev <= i_in.reverse_dir;
            r_btn <= i_in.buttons_n;
        end
    end

    // ---------------------------------------------------------------
    // Period register: a write takes effect at the next toggle, since
    // phase lengths are only reloaded there.
    // ---------------------------------------------------------------
    assign n_period = i_cfg_we ? i_cfg_wdata : r_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= mpds_pkg::PERIOD_RESET;
        end else begin
            r_period <= n_period;
        end
    end

    // ---------------------------------------------------------------
    // Duty and key handling.
    // ---------------------------------------------------------------
    assign w_ctrl.step         = w_step;
    assign w_ctrl.motor_enable = r_en;
    assign w_ctrl.buttons_n    = r_btn;

    mpds_duty_keys u_keys (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .o_duty      (w_duty),
        .o_duty_next (w_duty_next)
    );

    // On and off lengths for the current period and duty; the product
    // is registered inside so only the divide-by-100 sits in this path.
    mpds_phase_len #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_len (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_period      (r_period),
        .i_period_next (n_period),
        .i_duty_next   (w_duty_next),
        .o_on_len      (w_on_len),
        .o_off_len     (w_off_len)
    );

    // ---------------------------------------------------------------
    // Phase counter: a phase of length L lasts L+1 ticks. On a toggle,
    // load the length of the phase being entered.
    // ---------------------------------------------------------------
    assign w_toggle = (r_elapsed >= r_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level   <= 1'b0;
            r_elapsed <= '0;
            r_len     <= COUNTER_BITS'(LEN_RST);
        end else if (w_step) begin
            if (w_toggle) begin
                r_level   <= ~r_level;
                r_len     <= r_level ? w_off_len : w_on_len;
                r_elapsed <= '0;
            end else begin
                r_elapsed <= r_elapsed + COUNTER_BITS'(1);
            end
        end
    end

    // Pins come from the level before this tick's toggle; drop both when off.
    always_comb begin
        if (!r_en) begin
            w_pins = 2'b00;
        end else if (r_rev) begin
            w_pins = {r_level, 1'b0};
        end else begin
            w_pins = {1'b0, r_level};
        end
    end

    // ---------------------------------------------------------------
    // Output register: the result waits here while the next tick is taken.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_pins <= w_pins;
            r_out_duty <= w_duty_next;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.drive_pins   = r_out_pins;
    assign o_out.duty_percent = r_out_duty;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `MPDS_ASSERT_NOW(a_elapsed_in_phase, 1'b1, r_elapsed <= r_len, "counter passed phase length")
    `MPDS_ASSERT_NOW(a_duty_range, 1'b1, w_duty >= mpds_pkg::DUTY_MIN && w_duty <= mpds_pkg::DUTY_MAX, "duty out of range")
    `MPDS_ASSERT_NOW(a_one_pin, r_out_valid, !(r_out_pins[0] && r_out_pins[1]), "both pins driven")
    `MPDS_ASSERT_NEXT(a_disabled_low, w_step && !r_en, r_out_pins == 2'b00, "pins driven while disabled")
    `MPDS_ASSERT_NEXT(a_hold_time_base, !w_step, $stable(r_level) && $stable(r_elapsed), "time base moved without a tick")

endmodule
